/* rtl/core/coa_pkg.sv */
// Shared types and constants for the cursor overlay compositor.
`timescale 1ns / 1ps
`default_nettype none

package coa_pkg;

	localparam int COORD_W    = 11;
	localparam int EXTENT_W   = 12;
	localparam int RGB_W      = 24;
	localparam int ARGB_W     = 32;
	localparam int ALPHA_W    = 8;
	localparam int CHAN_W     = 8;
	localparam int SEL_W      = 3;
	localparam int IDX_W      = 10;
	localparam int GEOM_W     = 6;
	localparam int HOT_W      = 5;
	localparam int CMD_W      = 2;
	localparam int OFS_W      = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CMD_W-1:0] CMD_PIXEL  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SPRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_GEOM   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_SHAPE  = 3'd4;

	localparam logic [EXTENT_W-1:0] SCREEN_WIDTH_RST  = 12'd1280;
	localparam logic [EXTENT_W-1:0] SCREEN_HEIGHT_RST = 12'd720;
	localparam logic [COORD_W-1:0]  CURSOR_X_RST      = 11'd640;
	localparam logic [COORD_W-1:0]  CURSOR_Y_RST      = 11'd360;
	localparam logic [SEL_W-1:0]    CURSOR_SHAPE_RST  = 3'd0;

	localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [COORD_W-1:0] pix_x;
		logic [COORD_W-1:0] pix_y;
		logic [RGB_W-1:0]   bg_rgb;
		logic [SEL_W-1:0]   shape_sel;
		logic [IDX_W-1:0]   sprite_index;
		logic [ARGB_W-1:0]  sprite_argb;
		logic [GEOM_W-1:0]  geom_width;
		logic [GEOM_W-1:0]  geom_height;
		logic [HOT_W-1:0]   geom_hot_x;
		logic [HOT_W-1:0]   geom_hot_y;
	} in_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic [RGB_W-1:0]   out_rgb;
		logic               cursor_hit;
	} out_item_t;

endpackage

`default_nettype wire

/* rtl/core/coa_sprite_ram.sv */
// Sprite pixel memory: one write and one registered read port, write-first forwarding, clear sweep.
`timescale 1ns / 1ps
`default_nettype none

module coa_sprite_ram #(
	parameter int DEPTH = 7168,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         rd_en,
	input  wire  [AW-1:0]               rd_addr,
	output logic [coa_pkg::ARGB_W-1:0]  rd_data,
	input  wire                         wr_en,
	input  wire  [AW-1:0]               wr_addr,
	input  wire  [coa_pkg::ARGB_W-1:0]  wr_data,
	output logic                        busy
);
	import coa_pkg::*;

	logic [ARGB_W-1:0] mem [DEPTH];
	logic [ARGB_W-1:0] rd_data_q;
	logic [AW-1:0]     clr_q;
	logic              busy_q;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [ARGB_W-1:0] wdata;

	always_comb begin
		we    = busy_q || wr_en;
		waddr = busy_q ? clr_q : wr_addr;
		wdata = busy_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// a read of the entry being written this cycle returns the new word
		if (rd_en) begin
			if (wr_en && !busy_q && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

`default_nettype wire

/* rtl/core/coa_locate.sv */
// Shape geometry table, cursor clamp, sprite-relative offset stage and sprite address generation.
`timescale 1ns / 1ps
`default_nettype none

module coa_locate #(
	parameter int SPRITE_SIZE = 32,
	parameter int SHAPE_COUNT = 7,
	localparam int AW = $clog2(SHAPE_COUNT * SPRITE_SIZE * SPRITE_SIZE)
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           en,
	input  wire                           geom_we,
	input  wire coa_pkg::in_item_t        item,
	input  wire  [coa_pkg::EXTENT_W-1:0]  screen_width,
	input  wire  [coa_pkg::EXTENT_W-1:0]  screen_height,
	input  wire  [coa_pkg::COORD_W-1:0]   cursor_x,
	input  wire  [coa_pkg::COORD_W-1:0]   cursor_y,
	input  wire  [coa_pkg::SEL_W-1:0]     cursor_shape,
	output logic                          in_rect,
	output logic                          wr_ok,
	output logic [AW-1:0]                 addr
);
	import coa_pkg::*;

	localparam int PIX = SPRITE_SIZE * SPRITE_SIZE;
	localparam int SHW = (SHAPE_COUNT > 1) ? $clog2(SHAPE_COUNT) : 1;
	localparam int SCW = $clog2(SPRITE_SIZE);

	logic [GEOM_W-1:0] width_q  [SHAPE_COUNT];
	logic [GEOM_W-1:0] height_q [SHAPE_COUNT];
	logic [HOT_W-1:0]  hot_x_q  [SHAPE_COUNT];
	logic [HOT_W-1:0]  hot_y_q  [SHAPE_COUNT];

	logic              sel_ok;
	logic              cur_ok;
	logic [SHW-1:0]    wsel;
	logic [SHW-1:0]    cur;
	logic [EXTENT_W-1:0] cx;
	logic [EXTENT_W-1:0] cy;
	logic [OFS_W-1:0]  sx;
	logic [OFS_W-1:0]  sy;
	logic              on_scr;

	logic [OFS_W-1:0]  sx_s2;
	logic [OFS_W-1:0]  sy_s2;
	logic              on_s2;
	logic [GEOM_W-1:0] w_s2;
	logic [GEOM_W-1:0] h_s2;
	logic [SHW-1:0]    cur_s2;
	logic              pix_s2;
	logic [SHW-1:0]    sel_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic              wr_ok_s2;

	function automatic logic [GEOM_W-1:0] sat_size(logic [GEOM_W-1:0] v);
		return (int'(v) > SPRITE_SIZE) ? GEOM_W'(SPRITE_SIZE) : v;
	endfunction

	always_comb begin
		sel_ok = int'(item.shape_sel) < SHAPE_COUNT;
		cur_ok = int'(cursor_shape) < SHAPE_COUNT;
		wsel   = sel_ok ? SHW'(item.shape_sel) : '0;
		cur    = cur_ok ? SHW'(cursor_shape) : '0;
		// clamp the cursor to the last visible column and row
		cx = (EXTENT_W'(cursor_x) < screen_width) ? EXTENT_W'(cursor_x) : screen_width - 1'b1;
		cy = (EXTENT_W'(cursor_y) < screen_height) ? EXTENT_W'(cursor_y) : screen_height - 1'b1;
		sx = OFS_W'(item.pix_x) - OFS_W'(cx) + OFS_W'(hot_x_q[cur]);
		sy = OFS_W'(item.pix_y) - OFS_W'(cy) + OFS_W'(hot_y_q[cur]);
		on_scr = (EXTENT_W'(item.pix_x) < screen_width) &&
			(EXTENT_W'(item.pix_y) < screen_height) && cur_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SHAPE_COUNT; i++) begin
				width_q[i]  <= '0;
				height_q[i] <= '0;
				hot_x_q[i]  <= '0;
				hot_y_q[i]  <= '0;
			end
		end else if (geom_we && sel_ok) begin
			width_q[wsel]  <= sat_size(item.geom_width);
			height_q[wsel] <= sat_size(item.geom_height);
			hot_x_q[wsel]  <= item.geom_hot_x;
			hot_y_q[wsel]  <= item.geom_hot_y;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2    <= sx;
			sy_s2    <= sy;
			on_s2    <= on_scr;
			w_s2     <= width_q[cur];
			h_s2     <= height_q[cur];
			cur_s2   <= cur;
			pix_s2   <= (item.cmd == CMD_PIXEL);
			sel_s2   <= wsel;
			idx_s2   <= item.sprite_index;
			wr_ok_s2 <= sel_ok && (int'(item.sprite_index) < PIX);
		end
	end

	always_comb begin
		// offsets are two's complement; the top bit marks left of or above the sprite
		in_rect = pix_s2 && on_s2 && !sx_s2[OFS_W-1] && !sy_s2[OFS_W-1] &&
			(sx_s2 < OFS_W'(w_s2)) && (sy_s2 < OFS_W'(h_s2));
		wr_ok  = wr_ok_s2;
		if (pix_s2) begin
			addr = AW'(cur_s2) * AW'(PIX) + AW'(sy_s2[SCW-1:0]) * AW'(SPRITE_SIZE) +
				AW'(sx_s2[SCW-1:0]);
		end else begin
			addr = AW'(sel_s2) * AW'(PIX) + AW'(idx_s2);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/coa_blend.sv */
// Per-channel alpha blend: multiply stage, then divide by 255 without a divider.
`timescale 1ns / 1ps
`default_nettype none

module coa_blend (
	input  wire                         clk,
	input  wire                         en,
	input  wire  [coa_pkg::ARGB_W-1:0]  fg,
	input  wire  [coa_pkg::RGB_W-1:0]   bg,
	output logic [coa_pkg::RGB_W-1:0]   rgb
);
	import coa_pkg::*;

	localparam int NCH   = RGB_W / CHAN_W;
	localparam int MIX_W = 2 * CHAN_W;

	logic [ALPHA_W-1:0] a;
	logic [MIX_W-1:0]   mix [NCH];
	logic [MIX_W-1:0]   mix_s4 [NCH];

	always_comb begin
		a = fg[ARGB_W-1 -: ALPHA_W];
		for (int c = 0; c < NCH; c++) begin
			mix[c] = MIX_W'(bg[c*CHAN_W +: CHAN_W]) * MIX_W'(ALPHA_MAX - a) +
				MIX_W'(fg[c*CHAN_W +: CHAN_W]) * MIX_W'(a);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NCH; c++) begin
				mix_s4[c] <= mix[c];
			end
		end
	end

	// x / 255 == (x + (x >> 8) + 1) >> 8 for every x up to 255*255, the largest mix value
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			rgb[c*CHAN_W +: CHAN_W] = CHAN_W'(((MIX_W+1)'(mix_s4[c]) +
				(MIX_W+1)'(mix_s4[c] >> CHAN_W) + (MIX_W+1)'(1)) >> CHAN_W);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/cursor_overlay_alpha_compositor.sv */
// Cursor overlay compositor top level: pipeline control, configuration registers, output register.
//
// Usage: items enter on item_valid/item_stall; a request is taken when item_valid is high and
// item_stall is low. A scene pixel (cmd pixel) yields one result on result_valid/result_stall;
// sprite pixel writes, geometry writes and unknown commands pass through without a result.
// A scene pixel passes stages 1 to 4 and the output register, then shows on result.
// Throughput: one item per clock while item_stall is low; sprite memory is read once and
// written at most once per item (read in stage 2, alpha-compare write-back in stage 3, forwarded
// to a following read of the same entry), so back-to-back requests to one entry run at full rate.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// Registers are screen width, screen height, cursor column, cursor row and cursor shape.
// Reset: arst_n clears control state and the geometry table, then a clear sweep zeroes all
// SHAPE_COUNT*SPRITE_SIZE*SPRITE_SIZE sprite memory entries (7168 by default) with item_stall
// high. Configuration writes are taken during the sweep.
// Stall: a waiting result sits in the output register; upstream stages keep filling until the
// pipeline is full, then item_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module cursor_overlay_alpha_compositor #(
	parameter int SPRITE_SIZE = 32,
	parameter int SHAPE_COUNT = 7
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            item_valid,
	output logic                           item_stall,
	input  wire coa_pkg::in_item_t         item,
	output logic                           result_valid,
	input  wire                            result_stall,
	output coa_pkg::out_item_t             result,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [coa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [coa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import coa_pkg::*;

	localparam int DEPTH = SHAPE_COUNT * SPRITE_SIZE * SPRITE_SIZE;
	localparam int AW    = $clog2(DEPTH);

	logic [EXTENT_W-1:0] screen_width_q;
	logic [EXTENT_W-1:0] screen_height_q;
	logic [COORD_W-1:0]  cursor_x_q;
	logic [COORD_W-1:0]  cursor_y_q;
	logic [SEL_W-1:0]    cursor_shape_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic res_valid_q;
	out_item_t result_q;

	in_item_t item_s1, item_s2, item_s3;
	logic            loc_inside, loc_wr_ok;
	logic [AW-1:0]   loc_addr;
	logic            inside_s3, wr_ok_s3;
	logic [AW-1:0]   addr_s3;
	logic [ARGB_W-1:0] fg_s3;

	logic [COORD_W-1:0] x_s4, y_s4;
	logic [RGB_W-1:0]   bg_s4;
	logic [RGB_W-1:0]   mix_s4;
	logic               hit_s4, pix_s4;

	logic out_rdy, rdy1, rdy2, rdy3, rdy4;
	logic accept, geom_we, mem_we, busy;

	always_comb begin
		out_rdy    = !res_valid_q || !result_stall;
		rdy4       = !v_s4 || !pix_s4 || out_rdy;
		rdy3       = !v_s3 || rdy4;
		rdy2       = !v_s2 || rdy3;
		rdy1       = !v_s1 || rdy2;
		item_stall = busy || !rdy1;
		accept     = item_valid && !item_stall;
		geom_we    = v_s1 && rdy2 && (item_s1.cmd == CMD_GEOM);
		// keep the stored entry unless the new alpha is at least as high
		mem_we     = v_s3 && rdy4 && (item_s3.cmd == CMD_SPRITE) && wr_ok_s3 &&
			(item_s3.sprite_argb[ARGB_W-1 -: ALPHA_W] >= fg_s3[ARGB_W-1 -: ALPHA_W]);
	end

	coa_locate #(
		.SPRITE_SIZE (SPRITE_SIZE),
		.SHAPE_COUNT (SHAPE_COUNT)
	) u_locate (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (rdy2),
		.geom_we       (geom_we),
		.item          (item_s1),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.cursor_x      (cursor_x_q),
		.cursor_y      (cursor_y_q),
		.cursor_shape  (cursor_shape_q),
		.in_rect       (loc_inside),
		.wr_ok         (loc_wr_ok),
		.addr          (loc_addr)
	);

	coa_sprite_ram #(
		.DEPTH (DEPTH)
	) u_sprite_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rdy3),
		.rd_addr (loc_addr),
		.rd_data (fg_s3),
		.wr_en   (mem_we),
		.wr_addr (addr_s3),
		.wr_data (item_s3.sprite_argb),
		.busy    (busy)
	);

	coa_blend u_blend (
		.clk (clk),
		.en  (rdy4),
		.fg  (fg_s3),
		.bg  (item_s3.bg_rgb),
		.rgb (mix_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1            <= 1'b0;
			v_s2            <= 1'b0;
			v_s3            <= 1'b0;
			v_s4            <= 1'b0;
			res_valid_q     <= 1'b0;
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
			cursor_x_q      <= CURSOR_X_RST;
			cursor_y_q      <= CURSOR_Y_RST;
			cursor_shape_q  <= CURSOR_SHAPE_RST;
		end else begin
			if (rdy1) begin
				v_s1 <= accept;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (out_rdy) begin
				res_valid_q <= v_s4 && pix_s4;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SCREEN_WIDTH: begin
						screen_width_q <= cfg_data[EXTENT_W-1:0];
					end
					CFG_SCREEN_HEIGHT: begin
						screen_height_q <= cfg_data[EXTENT_W-1:0];
					end
					CFG_CURSOR_X: begin
						cursor_x_q <= cfg_data[COORD_W-1:0];
					end
					CFG_CURSOR_Y: begin
						cursor_y_q <= cfg_data[COORD_W-1:0];
					end
					CFG_CURSOR_SHAPE: begin
						cursor_shape_q <= cfg_data[SEL_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			item_s1 <= item;
		end
		if (rdy2) begin
			item_s2 <= item_s1;
		end
		if (rdy3) begin
			item_s3   <= item_s2;
			inside_s3 <= loc_inside;
			wr_ok_s3  <= loc_wr_ok;
			addr_s3   <= loc_addr;
		end
		if (rdy4) begin
			x_s4   <= item_s3.pix_x;
			y_s4   <= item_s3.pix_y;
			bg_s4  <= item_s3.bg_rgb;
			hit_s4 <= inside_s3 && (fg_s3[ARGB_W-1 -: ALPHA_W] != '0);
			pix_s4 <= (item_s3.cmd == CMD_PIXEL);
		end
		if (out_rdy) begin
			result_q.out_x      <= x_s4;
			result_q.out_y      <= y_s4;
			result_q.out_rgb    <= hit_s4 ? mix_s4 : bg_s4;
			result_q.cursor_hit <= hit_s4;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

endmodule

`default_nettype wire
